// ===== rtl/bscu_pkg.sv =====
package bscu_pkg;

	localparam int unsigned CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_AC1_AC2 = 3'd0,
		REG_AC3_AC4 = 3'd1,
		REG_AC5_AC6 = 3'd2,
		REG_B1_B2   = 3'd3,
		REG_MC_MD   = 3'd4,
		REG_OSS     = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		OP_TEMP  = 1'b0,
		OP_PRESS = 1'b1
	} op_t;

	typedef struct packed {
		logic        operation;
		logic [18:0] raw_value;
	} req_t;

	typedef struct packed {
		logic        kind;
		logic [31:0] reading;
		logic        divide_fault;
	} rsp_t;

	typedef struct packed {
		logic [31:0] ac1_ac2;
		logic [31:0] ac3_ac4;
		logic [31:0] ac5_ac6;
		logic [31:0] b1_b2;
		logic [31:0] mc_md;
		logic [1:0]  oss;
	} cal_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T1, ST_T2, ST_TDIV, ST_TWAIT, ST_T3,
		ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6, ST_P7, ST_P8, ST_P9,
		ST_PDIV, ST_PWAIT, ST_P10, ST_P11, ST_P12, ST_P13,
		ST_DONE
	} state_t;

	localparam logic [31:0] Coef1 = 32'd4000;
	localparam logic [31:0] Coef2 = 32'd32768;
	localparam logic [31:0] Coef3 = 32'd50000;
	localparam logic [31:0] CoefG = 32'd3038;
	localparam logic [31:0] CoefH = 32'hFFFF_E343;
	localparam logic [31:0] CoefI = 32'd3791;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
		return 32'($signed(v) >>> n);
	endfunction

endpackage

// ===== rtl/bscu_req_if.sv =====
interface bscu_req_if;
	logic             valid;
	logic             ready;
	bscu_pkg::req_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/bscu_rsp_if.sv =====
interface bscu_rsp_if;
	logic             valid;
	logic             ready;
	bscu_pkg::rsp_t   payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/bscu_front.sv =====
module bscu_front #(
	parameter int unsigned Depth = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	bscu_req_if.sink        req,
	output logic            q_valid,
	output bscu_pkg::req_t  q_item,
	input  logic            q_pop
);
	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	bscu_pkg::req_t mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [PtrW:0]   cnt_q;
	logic push;

	assign req.ready = (cnt_q != (PtrW+1)'(Depth));
	assign push = req.valid && req.ready;
	assign q_valid = (cnt_q != '0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= req.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PtrW+1)'(Depth)) else $error("queue overflow");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid) else $error("pop of empty queue");
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !q_pop) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count slip");
endmodule

// ===== rtl/bscu_div.sv =====
module bscu_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quotient
);
	logic [31:0] quo_q, den_q;
	logic [32:0] rem_q;
	logic [5:0]  cnt_q;
	logic [32:0] shifted, diff;

	assign busy = (cnt_q != '0);
	assign quotient = quo_q;
	assign shifted = {rem_q[31:0], quo_q[31]};
	assign diff = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy) begin
			if (!diff[32]) begin
				rem_q <= diff;
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy) else $error("divider restarted while busy");
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> cnt_q == 6'd32) else $error("divider count");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> rem_q[32] == 1'b0) else $error("remainder overflow");
endmodule

// ===== rtl/bscu_back.sv =====
module bscu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  bscu_pkg::cal_t  cal,
	input  logic            q_valid,
	input  bscu_pkg::req_t  q_item,
	output logic            q_pop,
	bscu_rsp_if.source      rsp
);
	bscu_pkg::state_t state_q, state_d;
	logic [31:0] b5_q, x1_q, b6_q, sq_q, x3_q, b3_q, b4_q, b7_q, p_q, t_q, acc_q, rd_q;
	logic        op_q, flt_q, swap_q;
	logic [18:0] raw_q;
	logic [31:0] ma, mb, mp;
	logic        dstart, dbusy;
	logic [31:0] dq, da, db, up, pq;
	logic        out_v_q;
	logic [31:0] mcs, den;
	logic        op_q_out, flt_out;

	assign mp = 32'(ma * mb);

	always_comb begin
		ma = '0;
		mb = '0;
		case (state_q)
			bscu_pkg::ST_T1: begin
				ma = {16'd0, raw_q[15:0]} - {16'd0, cal.ac5_ac6[15:0]};
				mb = {16'd0, cal.ac5_ac6[31:16]};
			end
			bscu_pkg::ST_P1: begin ma = b6_q; mb = b6_q; end
			bscu_pkg::ST_P2: begin ma = bscu_pkg::sx16(cal.b1_b2[15:0]); mb = sq_q; end
			bscu_pkg::ST_P3: begin ma = bscu_pkg::sx16(cal.ac1_ac2[15:0]); mb = b6_q; end
			bscu_pkg::ST_P5: begin ma = bscu_pkg::sx16(cal.ac3_ac4[31:16]); mb = b6_q; end
			bscu_pkg::ST_P6: begin ma = bscu_pkg::sx16(cal.b1_b2[31:16]); mb = sq_q; end
			bscu_pkg::ST_P7: begin
				ma = {16'd0, cal.ac3_ac4[15:0]};
				mb = x3_q + bscu_pkg::Coef2;
			end
			bscu_pkg::ST_P8: begin ma = up - b3_q; mb = bscu_pkg::Coef3 >> cal.oss; end
			bscu_pkg::ST_P11: begin ma = t_q; mb = t_q; end
			bscu_pkg::ST_P12: begin ma = t_q; mb = bscu_pkg::CoefG; end
			bscu_pkg::ST_P13: begin ma = bscu_pkg::CoefH; mb = p_q; end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign mcs = {bscu_pkg::sx16(cal.mc_md[31:16])} << 11;
	assign den = x1_q + bscu_pkg::sx16(cal.mc_md[15:0]);
	assign up = {13'd0, raw_q} & ((32'd1 << (5'd16 + {3'd0, cal.oss})) - 1'b1);
	assign dstart = (state_q == bscu_pkg::ST_TDIV) || (state_q == bscu_pkg::ST_PDIV);
	assign da = (state_q == bscu_pkg::ST_TDIV) ? (mcs[31] ? -mcs : mcs)
		: (b7_q[31] ? b7_q : {b7_q[30:0], 1'b0});
	assign db = (state_q == bscu_pkg::ST_TDIV) ? (den[31] ? -den : den) : b4_q;
	assign pq = b7_q[31] ? {dq[30:0], 1'b0} : dq;

	bscu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .dividend(da), .divisor(db),
		.busy(dbusy), .quotient(dq)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			bscu_pkg::ST_IDLE: if (q_valid) state_d =
				(q_item.operation == bscu_pkg::OP_PRESS) ? bscu_pkg::ST_P1 : bscu_pkg::ST_T1;
			bscu_pkg::ST_T1: state_d = bscu_pkg::ST_T2;
			bscu_pkg::ST_T2: state_d = (den == '0) ? bscu_pkg::ST_DONE : bscu_pkg::ST_TDIV;
			bscu_pkg::ST_TDIV: state_d = bscu_pkg::ST_TWAIT;
			bscu_pkg::ST_TWAIT: if (!dbusy) state_d = bscu_pkg::ST_T3;
			bscu_pkg::ST_T3: state_d = bscu_pkg::ST_DONE;
			bscu_pkg::ST_P1: state_d = bscu_pkg::ST_P2;
			bscu_pkg::ST_P2: state_d = bscu_pkg::ST_P3;
			bscu_pkg::ST_P3: state_d = bscu_pkg::ST_P4;
			bscu_pkg::ST_P4: state_d = bscu_pkg::ST_P5;
			bscu_pkg::ST_P5: state_d = bscu_pkg::ST_P6;
			bscu_pkg::ST_P6: state_d = bscu_pkg::ST_P7;
			bscu_pkg::ST_P7: state_d = bscu_pkg::ST_P8;
			bscu_pkg::ST_P8: state_d = bscu_pkg::ST_P9;
			bscu_pkg::ST_P9: state_d = (b4_q == '0) ? bscu_pkg::ST_DONE : bscu_pkg::ST_PDIV;
			bscu_pkg::ST_PDIV: state_d = bscu_pkg::ST_PWAIT;
			bscu_pkg::ST_PWAIT: if (!dbusy) state_d = bscu_pkg::ST_P10;
			bscu_pkg::ST_P10: state_d = bscu_pkg::ST_P11;
			bscu_pkg::ST_P11: state_d = bscu_pkg::ST_P12;
			bscu_pkg::ST_P12: state_d = bscu_pkg::ST_P13;
			bscu_pkg::ST_P13: state_d = bscu_pkg::ST_DONE;
			bscu_pkg::ST_DONE: if (!out_v_q || rsp.ready) state_d = bscu_pkg::ST_IDLE;
			default: state_d = bscu_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop = (state_q == bscu_pkg::ST_IDLE) && q_valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bscu_pkg::ST_IDLE;
			b5_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == bscu_pkg::ST_T3) b5_q <= x1_q + (swap_q ? -dq : dq);
			if (state_q == bscu_pkg::ST_DONE && (!out_v_q || rsp.ready)) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			bscu_pkg::ST_IDLE: begin op_q <= q_item.operation; raw_q <= q_item.raw_value;
				flt_q <= 1'b0; acc_q <= '0; b6_q <= b5_q - bscu_pkg::Coef1; end
			bscu_pkg::ST_T1: x1_q <= bscu_pkg::asr(mp, 5'd15);
			bscu_pkg::ST_T2: begin swap_q <= mcs[31] ^ den[31];
				if (den == '0) flt_q <= 1'b1; end
			bscu_pkg::ST_T3: acc_q <= bscu_pkg::asr(x1_q + (swap_q ? -dq : dq) + 32'd8, 5'd4);
			bscu_pkg::ST_P1: sq_q <= bscu_pkg::asr(mp, 5'd12);
			bscu_pkg::ST_P2: x3_q <= bscu_pkg::asr(mp, 5'd11);
			bscu_pkg::ST_P3: x3_q <= x3_q + bscu_pkg::asr(mp, 5'd11);
			bscu_pkg::ST_P4: b3_q <= bscu_pkg::asr(
				(((bscu_pkg::sx16(cal.ac1_ac2[31:16]) << 2) + x3_q) << cal.oss) + 32'd2, 5'd2);
			bscu_pkg::ST_P5: x3_q <= bscu_pkg::asr(mp, 5'd13);
			bscu_pkg::ST_P6: x3_q <= bscu_pkg::asr(x3_q + bscu_pkg::asr(mp, 5'd16) + 32'd2, 5'd2);
			bscu_pkg::ST_P7: b4_q <= mp >> 15;
			bscu_pkg::ST_P8: b7_q <= mp;
			bscu_pkg::ST_P9: if (b4_q == '0) flt_q <= 1'b1;
			bscu_pkg::ST_P10: begin p_q <= pq; t_q <= bscu_pkg::asr(pq, 5'd8); end
			bscu_pkg::ST_P11: t_q <= mp;
			bscu_pkg::ST_P12: x1_q <= bscu_pkg::asr(mp, 5'd16);
			bscu_pkg::ST_P13: acc_q <= p_q
				+ bscu_pkg::asr(x1_q + bscu_pkg::asr(mp, 5'd16) + bscu_pkg::CoefI, 5'd4);
			default: ;
		endcase
		if (state_q == bscu_pkg::ST_DONE && (!out_v_q || rsp.ready)) rd_q <= flt_q ? '0 : acc_q;
	end

	assign rsp.valid = out_v_q;
	assign rsp.payload = '{kind: op_q_out, reading: rd_q, divide_fault: flt_out};

	always_ff @(posedge clk) begin
		if (state_q == bscu_pkg::ST_DONE && (!out_v_q || rsp.ready)) begin
			op_q_out <= op_q;
			flt_out <= flt_q;
		end
	end
endmodule

// ===== rtl/barometric_sensor_compensation_unit.sv =====
// sequence: a temperature request runs T1, T2, the divider and T3; a pressure request runs
// P1 to P9, the divider and P10 to P13; a zero divisor skips the divider and flags a fault
// flow: one request at a time in the back end, which takes no new request until the result
// of the last is in the output register; a stalled result holds the back end
// a two-entry queue in front takes requests while the back end works
// reset: arst_n clears calibration, oversampling, stored b5 and all control state to zero
module barometric_sensor_compensation_unit #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	bscu_req_if.sink    req,
	bscu_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	bscu_pkg::cal_t cal_q;
	logic q_valid, q_pop;
	bscu_pkg::req_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_we) begin
			case (bscu_pkg::cfg_idx_t'(cfg_index))
				bscu_pkg::REG_AC1_AC2: cal_q.ac1_ac2 <= cfg_data;
				bscu_pkg::REG_AC3_AC4: cal_q.ac3_ac4 <= cfg_data;
				bscu_pkg::REG_AC5_AC6: cal_q.ac5_ac6 <= cfg_data;
				bscu_pkg::REG_B1_B2: cal_q.b1_b2 <= cfg_data;
				bscu_pkg::REG_MC_MD: cal_q.mc_md <= cfg_data;
				bscu_pkg::REG_OSS: cal_q.oss <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	bscu_front #(.Depth(QueueDepth)) u_front (
		.clk(clk), .arst_n(arst_n), .req(req),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
	);

	bscu_back u_back (
		.clk(clk), .arst_n(arst_n), .cal(cal_q),
		.q_valid(q_valid), .q_item(q_item), .q_pop(q_pop), .rsp(rsp)
	);
endmodule

// ===== sim/bscu_compensation_checker.sv =====
`timescale 1ns / 1ps

module bscu_compensation_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  bscu_pkg::req_t  req_payload,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  bscu_pkg::rsp_t  rsp_payload,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data,
	output int              failures,
	output int              pending,
	output int              temp_results,
	output int              press_results,
	output int              fault_results
);

	logic [31:0] w_ac1_ac2, w_ac3_ac4, w_ac5_ac6, w_b1_b2, w_mc_md;
	logic [1:0]  w_oss;
	logic [31:0] stored_b5;
	bscu_pkg::rsp_t expected_readings[$];

	function automatic logic [31:0] shr_s(input logic [31:0] v, input int n);
		return 32'($signed(v) >>> n);
	endfunction

	function automatic logic [31:0] hi16(input logic [31:0] w);
		return {{16{w[31]}}, w[31:16]};
	endfunction

	function automatic logic [31:0] lo16(input logic [31:0] w);
		return {{16{w[15]}}, w[15:0]};
	endfunction

	task automatic compensate(input bscu_pkg::req_t r);
		bscu_pkg::rsp_t e;
		logic [31:0] ut, x1, den, q, b5, up, b6, sq, x3, b3, b4, b7, p, t, y1, y2;
		logic [31:0] mask;
		e.kind = r.operation;
		e.reading = '0;
		e.divide_fault = 1'b0;
		if (r.operation == bscu_pkg::OP_TEMP) begin
			ut = {16'd0, r.raw_value[15:0]};
			x1 = shr_s(32'((ut - {16'd0, w_ac5_ac6[15:0]}) * {16'd0, w_ac5_ac6[31:16]}), 15);
			den = x1 + lo16(w_mc_md);
			if (den == 0) begin
				e.divide_fault = 1'b1;
			end else begin
				q = 32'($signed(hi16(w_mc_md) << 11) / $signed(den));
				b5 = x1 + q;
				stored_b5 = b5;
				e.reading = shr_s(b5 + 32'd8, 4);
			end
		end else begin
			mask = (32'd1 << (16 + w_oss)) - 32'd1;
			up = {13'd0, r.raw_value} & mask;
			b6 = stored_b5 - 32'd4000;
			sq = shr_s(32'(b6 * b6), 12);
			x3 = shr_s(32'(lo16(w_b1_b2) * sq), 11) + shr_s(32'(lo16(w_ac1_ac2) * b6), 11);
			b3 = shr_s(((32'(hi16(w_ac1_ac2) * 32'd4) + x3) << w_oss) + 32'd2, 2);
			x3 = shr_s(shr_s(32'(hi16(w_ac3_ac4) * b6), 13)
				+ shr_s(32'(hi16(w_b1_b2) * sq), 16) + 32'd2, 2);
			b4 = 32'({16'd0, w_ac3_ac4[15:0]} * (x3 + 32'd32768)) >> 15;
			b7 = 32'((up - b3) * (32'd50000 >> w_oss));
			if (b4 == 0) begin
				e.divide_fault = 1'b1;
			end else begin
				if (!b7[31]) p = (b7 << 1) / b4;
				else p = (b7 / b4) << 1;
				t = shr_s(p, 8);
				y1 = shr_s(32'(32'(t * t) * 32'd3038), 16);
				y2 = shr_s(32'(32'hFFFF_E343 * p), 16);
				e.reading = p + shr_s(y1 + y2 + 32'd3791, 4);
			end
		end
		expected_readings.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		bscu_pkg::rsp_t e;
		int bad;
		if (!arst_n) begin
			w_ac1_ac2 <= '0; w_ac3_ac4 <= '0; w_ac5_ac6 <= '0;
			w_b1_b2 <= '0; w_mc_md <= '0; w_oss <= '0;
			stored_b5 = '0;
			expected_readings.delete();
			failures <= 0;
			pending <= 0;
			temp_results <= 0; press_results <= 0; fault_results <= 0;
		end else begin
			if (cfg_we) begin
				case (bscu_pkg::cfg_idx_t'(cfg_index))
					bscu_pkg::REG_AC1_AC2: w_ac1_ac2 <= cfg_data;
					bscu_pkg::REG_AC3_AC4: w_ac3_ac4 <= cfg_data;
					bscu_pkg::REG_AC5_AC6: w_ac5_ac6 <= cfg_data;
					bscu_pkg::REG_B1_B2:   w_b1_b2 <= cfg_data;
					bscu_pkg::REG_MC_MD:   w_mc_md <= cfg_data;
					bscu_pkg::REG_OSS:     w_oss <= cfg_data[1:0];
					default: ;
				endcase
			end
			if (req_valid && req_ready) compensate(req_payload);
			if (rsp_valid && rsp_ready) begin
				if (expected_readings.size() == 0) begin
					$error("unexpected result %p", rsp_payload);
					failures <= failures + 1;
				end else begin
					e = expected_readings.pop_front();
					bad = 0;
					if (rsp_payload.kind !== e.kind) begin
						$error("kind expected %0d actual %0d", e.kind, rsp_payload.kind);
						bad = 1;
					end
					if (rsp_payload.reading !== e.reading) begin
						$error("reading expected %0d actual %0d",
							$signed(e.reading), $signed(rsp_payload.reading));
						bad = 1;
					end
					if (rsp_payload.divide_fault !== e.divide_fault) begin
						$error("divide_fault expected %0d actual %0d",
							e.divide_fault, rsp_payload.divide_fault);
						bad = 1;
					end
					failures <= failures + bad;
					if (e.kind == bscu_pkg::OP_TEMP) temp_results <= temp_results + 1;
					else press_results <= press_results + 1;
					if (e.divide_fault) fault_results <= fault_results + 1;
				end
			end
			pending <= expected_readings.size();
		end
	end

endmodule

// ===== sim/barometric_sensor_compensation_unit_test.sv =====
`timescale 1ns / 1ps

module barometric_sensor_compensation_unit_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;
	int          failures, pending, temp_results, press_results, fault_results;
	int          hold_off = 0;
	int          rsp_wait = 0;
	bit          stimulus_done = 1'b0;

	bscu_req_if req ();
	bscu_rsp_if rsp ();

	initial begin
		req.valid = 1'b0;
		req.payload = '0;
		rsp.ready = 1'b0;
	end

	always #6 clk = ~clk;

	barometric_sensor_compensation_unit dut (
		.clk, .arst_n, .req(req), .rsp(rsp), .cfg_we, .cfg_index, .cfg_data
	);

	bscu_compensation_checker checker_i (
		.clk, .arst_n,
		.req_valid(req.valid), .req_ready(req.ready), .req_payload(req.payload),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_payload(rsp.payload),
		.cfg_we, .cfg_index, .cfg_data,
		.failures, .pending, .temp_results, .press_results, .fault_results
	);

	task automatic write_reg(input bscu_pkg::cfg_idx_t idx, input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_request(input bscu_pkg::op_t op, input logic [18:0] raw,
		input bit may_gap);
		int gap;
		gap = may_gap ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.payload <= '{operation: op, raw_value: raw};
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain;
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// typical calibration words of the common part
	task automatic load_typical;
		write_reg(bscu_pkg::REG_AC1_AC2, {16'd408, -16'sd72});
		write_reg(bscu_pkg::REG_AC3_AC4, {-16'sd14383, 16'd32741});
		write_reg(bscu_pkg::REG_AC5_AC6, {16'd32757, 16'd23153});
		write_reg(bscu_pkg::REG_B1_B2, {16'd6190, 16'd4});
		write_reg(bscu_pkg::REG_MC_MD, {-16'sd8711, 16'd2868});
	endtask

	task automatic load_random;
		write_reg(bscu_pkg::REG_AC1_AC2, $urandom);
		write_reg(bscu_pkg::REG_AC3_AC4, $urandom);
		write_reg(bscu_pkg::REG_AC5_AC6, $urandom);
		write_reg(bscu_pkg::REG_B1_B2, $urandom);
		write_reg(bscu_pkg::REG_MC_MD, $urandom);
		write_reg(bscu_pkg::REG_OSS, 32'($urandom_range(0, 3)));
	endtask

	function automatic logic [18:0] raw_pick(input bscu_pkg::op_t op);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 19'($urandom);
			default: return op == bscu_pkg::OP_TEMP ? 19'($urandom_range(20000, 33000))
				: 19'($urandom_range(20000, 45000) << $urandom_range(0, 3));
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int gap;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			rsp_wait <= 0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rsp.ready <= 1'b0;
		end else if (rsp.valid && rsp.ready) begin
			gap = $urandom_range(0, 7);
			rsp_wait <= gap;
			rsp.ready <= (gap == 0);
		end else if (rsp_wait > 0) begin
			rsp_wait <= rsp_wait - 1;
			rsp.ready <= (rsp_wait == 1);
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	initial begin
		bscu_pkg::op_t op;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero calibration: pressure before any temperature, then temperature with divisor zero
		send_request(bscu_pkg::OP_PRESS, 19'h7FFFF, 1'b0);
		send_request(bscu_pkg::OP_TEMP, 19'd0, 1'b0);
		send_request(bscu_pkg::OP_TEMP, 19'h7FFFF, 1'b0);
		drain();
		load_typical();
		for (int s = 0; s < 4; s++) begin
			write_reg(bscu_pkg::REG_OSS, 32'(s));
			send_request(bscu_pkg::OP_TEMP, 19'd27898, 1'b0);
			send_request(bscu_pkg::OP_PRESS, 19'd23843 << s, 1'b0);
			send_request(bscu_pkg::OP_PRESS, 19'h7FFFF, 1'b0);
			send_request(bscu_pkg::OP_TEMP, 19'h7FFFF, 1'b0);
			drain();
		end
		// ac4 zero forces the pressure divisor to zero
		write_reg(bscu_pkg::REG_AC3_AC4, 32'hFFFF_0000);
		send_request(bscu_pkg::OP_PRESS, 19'd1000, 1'b0);
		drain();
		write_reg(bscu_pkg::REG_AC1_AC2, 32'hFFFF_FFFF);
		write_reg(bscu_pkg::REG_AC3_AC4, 32'h8000_FFFF);
		write_reg(bscu_pkg::REG_AC5_AC6, 32'hFFFF_FFFF);
		write_reg(bscu_pkg::REG_B1_B2, 32'h8000_7FFF);
		write_reg(bscu_pkg::REG_MC_MD, 32'h8000_8000);
		send_request(bscu_pkg::OP_TEMP, 19'd0, 1'b0);
		send_request(bscu_pkg::OP_PRESS, 19'h7FFFF, 1'b0);
		send_request(bscu_pkg::OP_PRESS, 19'd0, 1'b0);
		drain();

		for (int ph = 0; ph < 12; ph++) begin
			if (ph % 3 == 0) load_random();
			else begin
				load_typical();
				write_reg(bscu_pkg::REG_OSS, 32'($urandom_range(0, 3)));
			end
			if (ph == 4) hold_off = 400;
			for (int i = 0; i < 160; i++) begin
				op = ($urandom_range(0, 2) == 0) ? bscu_pkg::OP_TEMP : bscu_pkg::OP_PRESS;
				send_request(op, raw_pick(op), ph != 4);
			end
			drain();
		end
		stimulus_done = 1'b1;
	end

	initial begin
		wait (stimulus_done);
		$display("covered %0d temperature and %0d pressure results, %0d divide faults",
			temp_results, press_results, fault_results);
		if (failures == 0 && pending == 0) begin
			$display("barometric_sensor_compensation_unit_test OK");
		end else begin
			$display("barometric_sensor_compensation_unit_test NOT OK");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("barometric_sensor_compensation_unit_test NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bscu_pkg.sv
rtl/bscu_req_if.sv
rtl/bscu_rsp_if.sv
rtl/bscu_front.sv
rtl/bscu_div.sv
rtl/bscu_back.sv
rtl/barometric_sensor_compensation_unit.sv
sim/bscu_compensation_checker.sv
sim/barometric_sensor_compensation_unit_test.sv
